/* hw/rtl/rsa_pkg.sv */
// rsa_pkg: shared types for the row statistics accumulator
// no dependencies; imported by rsa_front and rsa_back
package rsa_pkg;

  // per-row status carried from the accumulator to the arithmetic back end
  typedef struct packed {
    logic empty;
    logic overflow;
  } row_flags_t;

endpackage

/* hw/rtl/rsa_front.sv */
// rsa_front: takes samples one per cycle and keeps running min, max, sum, sum of squares
// and count; at row end it pushes a packed row record into the queue
// depends on rsa_pkg
module rsa_front
  import rsa_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_end_of_row,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [2*SAMPLE_BITS+(SAMPLE_BITS+COUNT_BITS)+(2*SAMPLE_BITS+COUNT_BITS)
                +COUNT_BITS+$bits(row_flags_t)-1:0] q_rec
);

  localparam int S  = SAMPLE_BITS;
  localparam int C  = COUNT_BITS;
  localparam int SW = S + C;
  localparam int QW = 2 * S + C;

  logic [S-1:0]  min_r, min_nxt;
  logic [S-1:0]  max_r, max_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [QW-1:0] sumsq_r, sumsq_nxt;
  logic [C-1:0]  cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;

  logic          take;
  logic [S-1:0]  mag;
  logic [2*S-1:0] sq;
  row_flags_t    flags;

  // only a row end needs room in the queue
  assign in_stall = q_full & in_end_of_row;
  assign take     = in_valid & ~in_stall;
  assign q_push   = take & in_end_of_row;

  assign mag = in_sample[S-1] ? (~in_sample + S'(1)) : in_sample;
  assign sq  = mag * mag;

  assign flags.empty    = (cnt_r == '0);
  assign flags.overflow = ovf_r;
  assign q_rec = {min_r, max_r, sum_r, sumsq_r, cnt_r, flags};

  always_comb begin
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    if (take) begin
      if (in_end_of_row) begin
        min_nxt   = '0;
        max_nxt   = '0;
        sum_nxt   = '0;
        sumsq_nxt = '0;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else if (cnt_r == '1) begin
        // count saturated: sample dropped
        ovf_nxt = 1'b1;
      end else begin
        if (cnt_r == '0 || $signed(in_sample) < $signed(min_r)) min_nxt = in_sample;
        if (cnt_r == '0 || $signed(in_sample) > $signed(max_r)) max_nxt = in_sample;
        sum_nxt   = sum_r + {{C{in_sample[S-1]}}, in_sample};
        sumsq_nxt = sumsq_r + QW'(sq);
        cnt_nxt   = cnt_r + C'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

/* hw/rtl/rsa_queue.sv */
// rsa_queue: two-entry register queue of row records between front and back end
// no dependencies
module rsa_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       fill_r, fill_nxt;

  assign full     = (fill_r == 2'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

/* hw/rtl/rsa_back.sv */
// rsa_back: sequential arithmetic for one row record: shift-add multiplies, restoring
// divides and a bit-pair square root, then the registered result
// depends on rsa_pkg
module rsa_back
  import rsa_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  logic [2*SAMPLE_BITS+(SAMPLE_BITS+COUNT_BITS)+(2*SAMPLE_BITS+COUNT_BITS)
                +COUNT_BITS+$bits(row_flags_t)-1:0] q_rec,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_row_min,
  output logic [SAMPLE_BITS-1:0] out_row_max,
  output logic [SAMPLE_BITS:0]   out_row_range,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] out_mean_q8,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] out_std_dev_q8,
  output logic                   out_empty_row,
  output logic                   out_count_overflow
);

  localparam int S  = SAMPLE_BITS;
  localparam int C  = COUNT_BITS;
  localparam int F  = FRAC_BITS;
  localparam int SW = S + C;
  localparam int QW = 2 * S + C;
  localparam int SF = S + F;
  localparam int W  = 2 * S + 2 * C + 2 * F;
  localparam int RW = W / 2;
  localparam int CW = $clog2(W + 1);
  localparam logic [SF-1:0] NEG_ONE_Q = ~SF'((1 << F) - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL_NS = 3'd1;
  localparam logic [2:0] ST_MUL_SS = 3'd2;
  localparam logic [2:0] ST_MUL_NN = 3'd3;
  localparam logic [2:0] ST_DIV_V  = 3'd4;
  localparam logic [2:0] ST_ROOT   = 3'd5;
  localparam logic [2:0] ST_DIV_M  = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  // record fields
  logic [S-1:0]  rec_min, rec_max;
  logic [SW-1:0] rec_sum;
  logic [QW-1:0] rec_sumsq;
  logic [C-1:0]  rec_cnt;
  row_flags_t    rec_flags;

  assign {rec_min, rec_max, rec_sum, rec_sumsq, rec_cnt, rec_flags} = q_rec;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  ma_r, ma_nxt;
  logic [SW-1:0] mb_r, mb_nxt;
  logic [W-1:0]  nsq_r, nsq_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [W-1:0]  num_r, num_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [SW-1:0] mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [C-1:0]  n_r, n_nxt;
  logic [S-1:0]  min_r, min_nxt;
  logic [S-1:0]  max_r, max_nxt;
  row_flags_t    flags_r, flags_nxt;
  logic [SF-1:0] std_r, std_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [S-1:0]  o_min_r, o_min_nxt;
  logic [S-1:0]  o_max_r, o_max_nxt;
  logic [S:0]    o_range_r, o_range_nxt;
  logic [SF-1:0] o_mean_r, o_mean_nxt;
  logic [SF-1:0] o_std_r, o_std_nxt;
  row_flags_t    o_flags_r, o_flags_nxt;

  logic [W-1:0]  mul_sum;
  logic [W:0]    div_sh, sq_sh, sq_trial;
  logic          div_ge, sq_ge;
  logic          last_step;
  logic [SF-1:0] mean_mag;

  assign mul_sum   = acc_r + (mb_r[0] ? ma_r : '0);
  assign div_sh    = {rem_r, num_r[W-1]};
  assign div_ge    = (div_sh >= {1'b0, den_r});
  assign sq_sh     = {rem_r[W-2:0], num_r[W-1:W-2]};
  assign sq_trial  = (W + 1)'({root_r, 2'b01});
  assign sq_ge     = (sq_sh >= sq_trial);
  assign last_step = (step_r == CW'(1));
  assign mean_mag  = num_r[SF-1:0];

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    nsq_nxt       = nsq_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    flags_nxt     = flags_r;
    std_nxt       = std_r;
    o_min_nxt     = o_min_r;
    o_max_nxt     = o_max_r;
    o_range_nxt   = o_range_r;
    o_mean_nxt    = o_mean_r;
    o_std_nxt     = o_std_r;
    o_flags_nxt   = o_flags_r;
    out_valid_nxt = out_valid_r & out_stall;
    q_pop         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          min_nxt   = rec_min;
          max_nxt   = rec_max;
          n_nxt     = rec_cnt;
          flags_nxt = rec_flags;
          neg_nxt   = rec_sum[SW-1];
          mag_nxt   = rec_sum[SW-1] ? (~rec_sum + SW'(1)) : rec_sum;
          ma_nxt    = W'(rec_sumsq);
          mb_nxt    = SW'(rec_cnt);
          acc_nxt   = '0;
          step_nxt  = CW'(C);
          state_nxt = rec_flags.empty ? ST_DONE : ST_MUL_NS;
        end
      end
      ST_MUL_NS, ST_MUL_SS, ST_MUL_NN: begin
        acc_nxt  = mul_sum;
        ma_nxt   = {ma_r[W-2:0], 1'b0};
        mb_nxt   = {1'b0, mb_r[SW-1:1]};
        step_nxt = step_r - CW'(1);
        if (last_step) begin
          acc_nxt = '0;
          if (state_r == ST_MUL_NS) begin
            // n * sum of squares done, now sum squared
            nsq_nxt   = mul_sum;
            ma_nxt    = W'(mag_r);
            mb_nxt    = mag_r;
            step_nxt  = CW'(SW);
            state_nxt = ST_MUL_SS;
          end else if (state_r == ST_MUL_SS) begin
            num_nxt   = (nsq_r - mul_sum) << (2 * F);
            ma_nxt    = W'(n_r);
            mb_nxt    = SW'(n_r);
            step_nxt  = CW'(C);
            state_nxt = ST_MUL_NN;
          end else begin
            den_nxt   = mul_sum;
            rem_nxt   = '0;
            step_nxt  = CW'(W);
            state_nxt = ST_DIV_V;
          end
        end
      end
      ST_DIV_V, ST_DIV_M: begin
        rem_nxt  = div_ge ? W'(div_sh - {1'b0, den_r}) : W'(div_sh);
        num_nxt  = {num_r[W-2:0], div_ge};
        step_nxt = step_r - CW'(1);
        if (last_step) begin
          if (state_r == ST_DIV_V) begin
            rem_nxt   = '0;
            root_nxt  = '0;
            step_nxt  = CW'(RW);
            state_nxt = ST_ROOT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ROOT: begin
        rem_nxt  = sq_ge ? W'(sq_sh - sq_trial) : W'(sq_sh);
        root_nxt = {root_r[RW-2:0], sq_ge};
        num_nxt  = {num_r[W-3:0], 2'b00};
        step_nxt = step_r - CW'(1);
        if (last_step) begin
          std_nxt   = SF'(root_nxt);
          num_nxt   = W'(mag_r) << F;
          den_nxt   = W'(n_r);
          rem_nxt   = '0;
          step_nxt  = CW'(W);
          state_nxt = ST_DIV_M;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_flags_nxt   = flags_r;
          if (flags_r.empty) begin
            o_min_nxt          = '1;
            o_max_nxt          = '1;
            o_range_nxt        = '1;
            o_mean_nxt         = NEG_ONE_Q;
            o_std_nxt          = NEG_ONE_Q;
            o_flags_nxt.overflow = 1'b0;
          end else begin
            o_min_nxt   = min_r;
            o_max_nxt   = max_r;
            o_range_nxt = {max_r[S-1], max_r} - {min_r[S-1], min_r};
            o_mean_nxt  = neg_r ? (~mean_mag + SF'(1)) : mean_mag;
            o_std_nxt   = std_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    nsq_r     <= nsq_nxt;
    den_r     <= den_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    n_r       <= n_nxt;
    min_r     <= min_nxt;
    max_r     <= max_nxt;
    flags_r   <= flags_nxt;
    std_r     <= std_nxt;
    o_min_r   <= o_min_nxt;
    o_max_r   <= o_max_nxt;
    o_range_r <= o_range_nxt;
    o_mean_r  <= o_mean_nxt;
    o_std_r   <= o_std_nxt;
    o_flags_r <= o_flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row_min        = o_min_r;
  assign out_row_max        = o_max_r;
  assign out_row_range      = o_range_r;
  assign out_mean_q8        = o_mean_r;
  assign out_std_dev_q8     = o_std_r;
  assign out_empty_row      = o_flags_r.empty;
  assign out_count_overflow = o_flags_r.overflow;

endmodule

/* hw/rtl/row_statistics_accumulator.sv */
// row_statistics_accumulator: top level; front accumulator, row record queue, back end
// depends on rsa_front, rsa_queue, rsa_back (and rsa_pkg through them)
//
// usage: signed samples stream in on in_sample; a transaction with in_end_of_row set
// closes the row (its sample is ignored) and later yields one result transaction with
// min, max, range, mean and population std deviation (FRAC_BITS fraction bits).
// samples are taken one per cycle; in_stall rises only for a row end while both
// queue entries hold closed rows waiting for the back end.
// the back end works on one row record at a time with its single shared
// shift-add multiplier, restoring divider and root loop, while the front keeps
// accumulating and the queue holds up to two closed rows.
// an empty row reports all ones in min, max and range and -1.0 in mean and std
// deviation, with the empty flag; samples beyond the count limit are dropped and
// flagged as count overflow.
// the result is held in an output register; while out_stall is high it stays and the
// back end waits, the front keeps accumulating.
// reset (rst_n low, synchronous) clears the accumulators, queue and output valid.
module row_statistics_accumulator #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_end_of_row,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_row_min,
  output logic [SAMPLE_BITS-1:0] out_row_max,
  output logic [SAMPLE_BITS:0]   out_row_range,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] out_mean_q8,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] out_std_dev_q8,
  output logic                   out_empty_row,
  output logic                   out_count_overflow
);

  localparam int REC_BITS = 2 * SAMPLE_BITS + (SAMPLE_BITS + COUNT_BITS)
                            + (2 * SAMPLE_BITS + COUNT_BITS) + COUNT_BITS + 2;

  logic                q_full, q_empty, q_push, q_pop;
  logic [REC_BITS-1:0] rec_in, rec_out;

  rsa_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_end_of_row(in_end_of_row),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (rec_in)
  );

  rsa_queue #(
    .WIDTH(REC_BITS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(rec_in),
    .pop      (q_pop),
    .pop_data (rec_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  rsa_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rec             (rec_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row_min       (out_row_min),
    .out_row_max       (out_row_max),
    .out_row_range     (out_row_range),
    .out_mean_q8       (out_mean_q8),
    .out_std_dev_q8    (out_std_dev_q8),
    .out_empty_row     (out_empty_row),
    .out_count_overflow(out_count_overflow)
  );

endmodule

/* hw/rtl/rsa_checker.sv */
// rsa_checker: port-level checks on row_statistics_accumulator, attached by bind
// depends on row_statistics_accumulator ports only
module rsa_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   in_end_of_row,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_row_min,
  input logic [SAMPLE_BITS-1:0] out_row_max,
  input logic [SAMPLE_BITS:0]   out_row_range,
  input logic [SAMPLE_BITS+FRAC_BITS-1:0] out_mean_q8,
  input logic [SAMPLE_BITS+FRAC_BITS-1:0] out_std_dev_q8,
  input logic                   out_empty_row,
  input logic                   out_count_overflow
);

  localparam int SF = SAMPLE_BITS + FRAC_BITS;
  localparam logic [SF-1:0] NEG_ONE_Q = ~SF'((1 << FRAC_BITS) - 1);

  logic [SAMPLE_BITS:0] range_calc;
  assign range_calc = {out_row_max[SAMPLE_BITS-1], out_row_max}
                      - {out_row_min[SAMPLE_BITS-1], out_row_min};

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // samples are never held back, only row ends
  a_stall_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> in_end_of_row)
    else $error("stall on a plain sample");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_row |-> out_row_range == range_calc)
    else $error("range does not match max minus min");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_row |-> !out_count_overflow && out_row_min == '1
      && out_row_max == '1 && out_row_range == '1 && out_mean_q8 == NEG_ONE_Q
      && out_std_dev_q8 == NEG_ONE_Q)
    else $error("bad empty row result");

  a_std_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_row |-> !out_std_dev_q8[SAMPLE_BITS+FRAC_BITS-1])
    else $error("negative deviation on non-empty row");

endmodule

bind row_statistics_accumulator rsa_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_rsa_checker (.*);

/* tb/tb_row_statistics_accumulator.sv */
// tb_row_statistics_accumulator: self-checking bench for the row statistics accumulator
// drives rows of signed samples, predicts per-row min/max/range/mean/std deviation
// depends on row_statistics_accumulator only
`timescale 1ns / 100ps

module tb_row_statistics_accumulator;

  localparam int SB = 16;
  localparam int CB = 16;
  localparam int FB = 8;
  localparam int WD = SB + FB;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int COUNT_LIMIT = (1 << CB) - 1;

  typedef struct packed {
    logic [SB-1:0] row_min;
    logic [SB-1:0] row_max;
    logic [SB:0]   row_range;
    logic [WD-1:0] mean;
    logic [WD-1:0] std_dev;
    logic          empty;
    logic          overflow;
  } row_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SB-1:0] in_sample = '0;
  logic in_end_of_row = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  row_stats_t got;

  row_statistics_accumulator #(.SAMPLE_BITS(SB), .COUNT_BITS(CB), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_end_of_row(in_end_of_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row_min(got.row_min), .out_row_max(got.row_max), .out_row_range(got.row_range),
    .out_mean_q8(got.mean), .out_std_dev_q8(got.std_dev),
    .out_empty_row(got.empty), .out_count_overflow(got.overflow)
  );

  always #5 clk = ~clk;

  // predictor state for the open row
  longint acc_min, acc_max, acc_sum;
  longint unsigned acc_sq, acc_n;
  bit acc_ovf;
  row_stats_t stats_queue[$];
  int errors = 0;
  int idle_pct = 7;
  int idle_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic clear_row();
    acc_min = 0; acc_max = 0; acc_sum = 0; acc_sq = 0; acc_n = 0; acc_ovf = 0;
  endtask

  task automatic predict_row(input logic [SB-1:0] smp, input logic eor);
    longint s;
    longint unsigned mag, q, r, d, nn;
    row_stats_t e;
    if (!eor) begin
      s = longint'($signed(smp));
      if (acc_n >= COUNT_LIMIT) begin
        acc_ovf = 1;
        return;
      end
      if (acc_n == 0 || s < acc_min) acc_min = s;
      if (acc_n == 0 || s > acc_max) acc_max = s;
      acc_sum += s;
      mag = s < 0 ? -s : s;
      acc_sq += mag * mag;
      acc_n++;
      return;
    end
    if (acc_n == 0) begin
      e.row_min = '1; e.row_max = '1; e.row_range = '1;
      e.mean = WD'(-(1 << FB)); e.std_dev = WD'(-(1 << FB));
      e.empty = 1; e.overflow = 0;
    end else begin
      e.row_min = acc_min[SB-1:0];
      e.row_max = acc_max[SB-1:0];
      e.row_range = (SB+1)'(acc_max - acc_min);
      mag = acc_sum < 0 ? -acc_sum : acc_sum;
      q = (mag << FB) / acc_n;
      e.mean = WD'(acc_sum < 0 ? -q : q);
      d = acc_n * acc_sq - mag * mag;
      nn = acc_n * acc_n;
      q = d / nn;
      r = d % nn;
      for (int i = 0; i < 2 * FB; i++) begin
        r <<= 1;
        q <<= 1;
        if (r >= nn) begin
          r -= nn;
          q |= 1;
        end
      end
      e.std_dev = WD'(int_sqrt(q));
      e.empty = 0;
      e.overflow = acc_ovf;
    end
    stats_queue.push_back(e);
    clear_row();
  endtask

  task automatic send_sample(input logic [SB-1:0] smp, input logic eor);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    in_end_of_row <= eor;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_row(smp, eor);
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (stats_queue.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        row_stats_t e;
        e = stats_queue.pop_front();
        if (e.row_min !== got.row_min)
          $display("%0t: row_min exp %h got %h", $time, e.row_min, got.row_min);
        if (e.row_max !== got.row_max)
          $display("%0t: row_max exp %h got %h", $time, e.row_max, got.row_max);
        if (e.row_range !== got.row_range)
          $display("%0t: row_range exp %h got %h", $time, e.row_range, got.row_range);
        if (e.mean !== got.mean)
          $display("%0t: mean_q8 exp %h got %h", $time, e.mean, got.mean);
        if (e.std_dev !== got.std_dev)
          $display("%0t: std_dev_q8 exp %h got %h", $time, e.std_dev, got.std_dev);
        if (e.empty !== got.empty)
          $display("%0t: empty_row exp %b got %b", $time, e.empty, got.empty);
        if (e.overflow !== got.overflow)
          $display("%0t: count_overflow exp %b got %b", $time, e.overflow, got.overflow);
        if (e !== got) errors++;
      end
    end
  end

  // output stall
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < idle_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_sample(16'h0000, 1'b1);            // empty row
    send_sample(16'h7fff, 1'b0);            // single sample row
    send_sample(16'h1234, 1'b1);            // sample with row end ignored
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);            // full range
    send_sample(16'hffff, 1'b1);
    for (int i = 0; i < 6; i++) send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0005, 1'b0);
    send_sample(16'hfffb, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0000, 1'b1);            // back-to-back row ends, the second row empty
  endtask

  task automatic test_random_rows();
    int len;
    for (int row = 0; row < 30; row++) begin
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(3) == 0)
          send_sample(SB'($urandom_range(1) ? 32'h7fff - $urandom_range(3) :
                          32'h8000 + $urandom_range(3)), 1'b0);
        else
          send_sample(SB'($urandom()), 1'b0);
      end
      send_sample(SB'($urandom()), 1'b1);
    end
  endtask

  // long stretch with no idling on either side, extreme samples
  task automatic test_no_idle_stretch();
    idle_pct = 0;
    for (int row = 0; row < 8; row++) begin
      for (int i = 0; i < 20; i++)
        send_sample(($urandom_range(1) ? 16'h8000 : 16'h7fff), 1'b0);
      send_sample(16'h0000, 1'b1);
    end
    idle_pct = 7;
  endtask

  task automatic test_short_rows_pressure();
    for (int row = 0; row < 40; row++) begin
      for (int i = 0; i < $urandom_range(0, 2); i++) send_sample(SB'($urandom()), 1'b0);
      send_sample(SB'($urandom()), 1'b1);
    end
  endtask

  initial begin
    clear_row();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_rows();
    test_short_rows_pressure();
    test_no_idle_stretch();
    test_random_rows();
    in_valid <= 1'b0;
    while (stats_queue.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && stats_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rsa_pkg.sv
hw/rtl/rsa_front.sv
hw/rtl/rsa_queue.sv
hw/rtl/rsa_back.sv
hw/rtl/row_statistics_accumulator.sv
hw/rtl/rsa_checker.sv
tb/tb_row_statistics_accumulator.sv
